/* rtl/core/rmq_pkg.sv */
// Shared widths, constants and types for the rotation matrix to quaternion core.
// Used by the core and by its port checker; depends on nothing.
package rmq_pkg;

    localparam int ELEM_W     = 32;
    localparam int THR_W      = 17;
    localparam int WIDE_W     = 35;
    localparam int T_W        = 33;
    localparam int ROOT_SHIFT = 28;
    localparam int RAD_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int SQ_STEPS   = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DIV_STEPS  = 40;
    localparam int DREM_W     = ROOT_W;
    localparam int S_W        = DIV_STEPS;
    localparam int S_SPLIT    = 20;
    localparam int MAG_W      = WIDE_W;
    localparam int PROD_W     = MAG_W + S_SPLIT;
    localparam int SUM_W      = PROD_W + 1;
    localparam int LANES      = 4;
    localparam int LATENCY    = 2 + SQ_STEPS + DIV_STEPS + 3;

    localparam logic signed [WIDE_W-1:0] ONE_Q16       = WIDE_W'(65536);
    localparam logic [THR_W-1:0]         THR_RESET     = THR_W'(1);
    localparam logic [DREM_W-1:0]        DIV_REM_INIT  = DREM_W'(14'h2000);
    localparam logic [SUM_W-1:0]         ROUND_HALF    = SUM_W'(2048);
    localparam logic [SUM_W-13:0]        POS_LIMIT     = (SUM_W-12)'(32'h7FFF_FFFF);
    localparam logic [SUM_W-13:0]        NEG_LIMIT     = (SUM_W-12)'(32'h8000_0000);

    typedef struct packed {
        logic                     bad;
        logic signed [WIDE_W-1:0] ax;
        logic signed [WIDE_W-1:0] ay;
        logic signed [WIDE_W-1:0] az;
        logic signed [WIDE_W-1:0] aw;
    } side_t;

endpackage

/* rtl/core/rotation_matrix_to_quaternion_core.sv */
// Pipelined rotation matrix to quaternion conversion in Q16.16.
// Depends on rmq_pkg for widths, constants and the side payload type.
//
// Usage: a request (nine matrix elements) is taken at any rising edge with
// start high; busy is tied low, so a new request may enter every cycle.
// Each result appears on quat_x/y/z/w and bad_input for exactly one cycle
// with done high, after passing through every pipeline stage, in request order.
// Throughput is one matrix per cycle. The latency is set by the square root
// (31 stages, one root bit each), the reciprocal divider (40 stages, one
// quotient bit each), two setup stages and three multiply and output stages.
// The threshold register is written through cfg_we and cfg_wdata and should
// only change while no requests are in flight. Reset clears all valid bits
// and the done strobe and sets the threshold to one LSB. The receiver has
// no way to stall the pipeline; results must be taken when done is high.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [THR_W-1:0]         cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEM_W-1:0] elem_r0c0,
    input  logic signed [ELEM_W-1:0] elem_r0c1,
    input  logic signed [ELEM_W-1:0] elem_r0c2,
    input  logic signed [ELEM_W-1:0] elem_r1c0,
    input  logic signed [ELEM_W-1:0] elem_r1c1,
    input  logic signed [ELEM_W-1:0] elem_r1c2,
    input  logic signed [ELEM_W-1:0] elem_r2c0,
    input  logic signed [ELEM_W-1:0] elem_r2c1,
    input  logic signed [ELEM_W-1:0] elem_r2c2,
    output logic                     done,
    output logic signed [ELEM_W-1:0] quat_x,
    output logic signed [ELEM_W-1:0] quat_y,
    output logic signed [ELEM_W-1:0] quat_z,
    output logic signed [ELEM_W-1:0] quat_w,
    output logic                     bad_input
);

    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // Stage A: trace, branch flags, candidate t values and off-diagonal pairs.
    logic signed [WIDE_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [WIDE_W-1:0] trace;
    logic signed [WIDE_W-1:0] thr_ext;

    assign e00 = WIDE_W'(elem_r0c0);
    assign e01 = WIDE_W'(elem_r0c1);
    assign e02 = WIDE_W'(elem_r0c2);
    assign e10 = WIDE_W'(elem_r1c0);
    assign e11 = WIDE_W'(elem_r1c1);
    assign e12 = WIDE_W'(elem_r1c2);
    assign e20 = WIDE_W'(elem_r2c0);
    assign e21 = WIDE_W'(elem_r2c1);
    assign e22 = WIDE_W'(elem_r2c2);
    assign trace = e00 + e11 + e22;
    assign thr_ext = $signed(WIDE_W'(thr_reg));

    logic                     va_reg;
    logic                     tr_gt_reg, b0_reg, b1_reg;
    logic signed [WIDE_W-1:0] t_tr_reg, t0_reg, t1_reg, t2_reg;
    logic signed [WIDE_W-1:0] dx_reg, dy_reg, dz_reg, sxy_reg, sxz_reg, syz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_gt_reg <= trace > thr_ext;
        b0_reg    <= (e00 > e11) && (e00 > e22);
        b1_reg    <= e11 > e22;
        t_tr_reg  <= trace + ONE_Q16;
        t0_reg    <= ONE_Q16 + e00 - e11 - e22;
        t1_reg    <= ONE_Q16 + e11 - e00 - e22;
        t2_reg    <= ONE_Q16 + e22 - e00 - e11;
        dx_reg    <= e12 - e21;
        dy_reg    <= e20 - e02;
        dz_reg    <= e01 - e10;
        sxy_reg   <= e10 + e01;
        sxz_reg   <= e02 + e20;
        syz_reg   <= e21 + e12;
    end

    // Stage B: branch selection and root argument.
    logic signed [WIDE_W-1:0] t_sel;
    side_t                    side_b;
    logic [RAD_W-1:0]         rad_b;

    always_comb
    begin
        if (tr_gt_reg)
        begin
            t_sel     = t_tr_reg;
            side_b.ax = dx_reg;
            side_b.ay = dy_reg;
            side_b.az = dz_reg;
            side_b.aw = t_tr_reg;
        end
        else if (b0_reg)
        begin
            t_sel     = t0_reg;
            side_b.ax = t0_reg;
            side_b.ay = sxy_reg;
            side_b.az = sxz_reg;
            side_b.aw = dx_reg;
        end
        else if (b1_reg)
        begin
            t_sel     = t1_reg;
            side_b.ax = sxy_reg;
            side_b.ay = t1_reg;
            side_b.az = syz_reg;
            side_b.aw = dy_reg;
        end
        else
        begin
            t_sel     = t2_reg;
            side_b.ax = sxz_reg;
            side_b.ay = syz_reg;
            side_b.az = t2_reg;
            side_b.aw = dz_reg;
        end
        side_b.bad = t_sel <= 0;
        rad_b = side_b.bad ? '0 : RAD_W'({t_sel[T_W-1:0], {ROOT_SHIFT{1'b0}}});
    end

    logic             vb_reg;
    side_t            side_b_reg;
    logic [RAD_W-1:0] rad_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side_b_reg <= side_b;
        rad_b_reg  <= rad_b;
    end

    // Square root, one result bit per stage.
    logic              sq_v_reg    [0:SQ_STEPS-1];
    side_t             sq_side_reg [0:SQ_STEPS-1];
    logic [RAD_W-1:0]  sq_rad_reg  [0:SQ_STEPS-1];
    logic [REM_W-1:0]  sq_rem_reg  [0:SQ_STEPS-1];
    logic [ROOT_W-1:0] sq_root_reg [0:SQ_STEPS-1];

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        logic              v_in;
        side_t             side_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W+1:0]  x;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign v_in    = vb_reg;
            assign side_in = side_b_reg;
            assign rad_in  = rad_b_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign v_in    = sq_v_reg[i-1];
            assign side_in = sq_side_reg[i-1];
            assign rad_in  = sq_rad_reg[i-1];
            assign rem_in  = sq_rem_reg[i-1];
            assign root_in = sq_root_reg[i-1];
        end

        assign x     = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = (REM_W+2)'({root_in, 2'b01});
        assign ge    = x >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[i] <= 1'b0;
            end
            else
            begin
                sq_v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_side_reg[i] <= side_in;
            sq_rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
            sq_rem_reg[i]  <= ge ? REM_W'(x - trial) : x[REM_W-1:0];
            sq_root_reg[i] <= {root_in[ROOT_W-2:0], ge};
        end
    end

    // Reciprocal s = (2^53 + r/2) / r, one quotient bit per stage.
    logic               dv_v_reg    [0:DIV_STEPS-1];
    side_t              dv_side_reg [0:DIV_STEPS-1];
    logic [S_W-1:0]     dv_num_reg  [0:DIV_STEPS-1];
    logic [DREM_W-1:0]  dv_rem_reg  [0:DIV_STEPS-1];
    logic [ROOT_W-1:0]  dv_den_reg  [0:DIV_STEPS-1];
    logic [S_W-1:0]     dv_q_reg    [0:DIV_STEPS-1];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic              v_in;
        side_t             side_in;
        logic [S_W-1:0]    num_in;
        logic [DREM_W-1:0] rem_in;
        logic [ROOT_W-1:0] den_in;
        logic [S_W-1:0]    q_in;
        logic [DREM_W:0]   x;
        logic              ge;

        if (j == 0)
        begin : g_first
            logic [ROOT_W-1:0] r;
            assign r       = sq_root_reg[SQ_STEPS-1];
            assign v_in    = sq_v_reg[SQ_STEPS-1];
            assign side_in = sq_side_reg[SQ_STEPS-1];
            assign num_in  = S_W'(r[ROOT_W-1:1]);
            assign rem_in  = DIV_REM_INIT;
            assign den_in  = r;
            assign q_in    = '0;
        end
        else
        begin : g_next
            assign v_in    = dv_v_reg[j-1];
            assign side_in = dv_side_reg[j-1];
            assign num_in  = dv_num_reg[j-1];
            assign rem_in  = dv_rem_reg[j-1];
            assign den_in  = dv_den_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
        end

        assign x  = {rem_in, num_in[S_W-1]};
        assign ge = x >= (DREM_W+1)'(den_in);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else
            begin
                dv_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_side_reg[j] <= side_in;
            dv_num_reg[j]  <= {num_in[S_W-2:0], 1'b0};
            dv_rem_reg[j]  <= ge ? DREM_W'(x - (DREM_W+1)'(den_in)) : x[DREM_W-1:0];
            dv_den_reg[j]  <= den_in;
            dv_q_reg[j]    <= {q_in[S_W-2:0], ge};
        end
    end

    // Scaling: magnitude, split products, rounding and saturation.
    side_t                    side_d;
    logic [S_W-1:0]           s_d;
    logic signed [WIDE_W-1:0] lane_a [0:LANES-1];

    assign side_d    = dv_side_reg[DIV_STEPS-1];
    assign s_d       = dv_q_reg[DIV_STEPS-1];
    assign lane_a[0] = side_d.ax;
    assign lane_a[1] = side_d.ay;
    assign lane_a[2] = side_d.az;
    assign lane_a[3] = side_d.aw;

    logic                 m1_v_reg, m1_bad_reg;
    logic [S_W-1:0]       m1_s_reg;
    logic                 m1_neg_reg [0:LANES-1];
    logic [MAG_W-1:0]     m1_mag_reg [0:LANES-1];
    logic                 m2_v_reg, m2_bad_reg;
    logic                 m2_neg_reg [0:LANES-1];
    logic [PROD_W-1:0]    m2_hi_reg  [0:LANES-1];
    logic [PROD_W-1:0]    m2_lo_reg  [0:LANES-1];
    logic [ELEM_W-1:0]    lane_out   [0:LANES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end
        else
        begin
            m1_v_reg <= dv_v_reg[DIV_STEPS-1];
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_bad_reg <= side_d.bad;
        m1_s_reg   <= s_d;
        m2_bad_reg <= m1_bad_reg;
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic [SUM_W-1:0]    sum;
        logic [SUM_W-13:0]   q;
        logic [SUM_W-13:0]   q_sat;

        always_ff @(posedge clk)
        begin
            m1_neg_reg[k] <= lane_a[k] < 0;
            m1_mag_reg[k] <= lane_a[k] < 0 ? MAG_W'(-lane_a[k]) : MAG_W'(lane_a[k]);
            m2_neg_reg[k] <= m1_neg_reg[k];
            m2_hi_reg[k]  <= m1_mag_reg[k] * m1_s_reg[S_W-1:S_SPLIT];
            m2_lo_reg[k]  <= m1_mag_reg[k] * m1_s_reg[S_SPLIT-1:0];
        end

        always_comb
        begin
            sum = SUM_W'(m2_hi_reg[k]) + ROUND_HALF + SUM_W'(m2_lo_reg[k] >> S_SPLIT);
            q   = sum[SUM_W-1:12];
            if (m2_neg_reg[k])
            begin
                q_sat       = (q > NEG_LIMIT) ? NEG_LIMIT : q;
                lane_out[k] = ELEM_W'(-q_sat);
            end
            else
            begin
                q_sat       = (q > POS_LIMIT) ? POS_LIMIT : q;
                lane_out[k] = q_sat[ELEM_W-1:0];
            end
        end
    end

    logic                     done_reg, bad_reg;
    logic signed [ELEM_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            bad_reg  <= 1'b0;
            qx_reg   <= '0;
            qy_reg   <= '0;
            qz_reg   <= '0;
            qw_reg   <= '0;
        end
        else
        begin
            done_reg <= m2_v_reg;
            bad_reg  <= m2_bad_reg;
            qx_reg   <= m2_bad_reg ? '0 : $signed(lane_out[0]);
            qy_reg   <= m2_bad_reg ? '0 : $signed(lane_out[1]);
            qz_reg   <= m2_bad_reg ? '0 : $signed(lane_out[2]);
            qw_reg   <= m2_bad_reg ? '0 : $signed(lane_out[3]);
        end
    end

    assign done      = done_reg;
    assign bad_input = bad_reg;
    assign quat_x    = qx_reg;
    assign quat_y    = qy_reg;
    assign quat_z    = qz_reg;
    assign quat_w    = qw_reg;

endmodule

/* rtl/core/rmq_checker.sv */
// Port-level checker for the rotation matrix to quaternion core, with its bind.
// Depends on rmq_pkg for the pipeline latency and field widths.
module rmq_checker
    import rmq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic signed [ELEM_W-1:0] quat_x,
    input logic signed [ELEM_W-1:0] quat_y,
    input logic signed [ELEM_W-1:0] quat_z,
    input logic signed [ELEM_W-1:0] quat_w,
    input logic                     bad_input
);

    logic [$clog2(LATENCY+1)-1:0] age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else if (age_reg != ($clog2(LATENCY+1))'(LATENCY))
        begin
            age_reg <= age_reg + 1'b1;
        end
    end

    // The pipeline never pushes back on requests.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Once the age counter saturates, done must match start seen back through the whole pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (age_reg == ($clog2(LATENCY+1))'(LATENCY)) |->
        (done == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match request history");

    // A rejected matrix yields an all-zero quaternion.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_input) |->
        (quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0))
        else $error("nonzero quaternion with bad_input");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .bad_input (bad_input)
);
